[src/sbsm_pkg.sv]
package sbsm_pkg;

   // signature characters laid end to end, one match cell each
   localparam int unsigned PatBits = 54;
   localparam int unsigned NumSigs = 5;

   // first character of the string sits in the top byte
   localparam logic [PatBits*8-1:0] PatString =
      {"eval(base64", "_decode<?php system/bin/shcmd.exepowershell"};

   // cells that open a signature: 0, 18, 30, 37, 44
   localparam logic [PatBits-1:0] StartMask =
      (54'd1 << 0) | (54'd1 << 18) | (54'd1 << 30) | (54'd1 << 37) | (54'd1 << 44);

   // cells that close a signature, in signature order
   localparam int unsigned SigEnd [NumSigs] = '{17, 29, 36, 43, 53};

   // per-transaction control handed to every cell
   typedef struct packed {
      logic adv;  // shift the match chain with this byte
      logic clr;  // packet done, drop all partial matches
   } sbsm_ctl_type;

   function automatic logic [7:0] pat_char(input int unsigned k);
      return PatString[(PatBits-1-k)*8 +: 8];
   endfunction

endpackage

[src/sbsm_cell.sv]
module sbsm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sbsm_pkg::sbsm_ctl_type ctl,
   input  logic [7:0]            data_byte,
   input  logic [7:0]            pat_byte,
   input  logic                  start,
   input  logic                  prev_bit,
   output logic                  match_bit,
   output logic                  match_nx
);

   logic bit_ff;
   logic bit_in;

   // extend the neighbor's partial match, or open a new one at a signature start
   assign match_nx = (prev_bit | start) & (data_byte == pat_byte);

   always_comb begin
      if (ctl.clr) begin
         bit_in = 1'b0;
      end else if (ctl.adv) begin
         bit_in = match_nx;
      end else begin
         bit_in = bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign match_bit = bit_ff;

endmodule

[src/signature_byte_stream_matcher_core.sv]
// channel | direction | tdata                     | tuser | tlast
// req     | in        | [7:0] data_byte           | -     | last byte of packet
// rsp     | out       | [4:0] found_mask, [7:5] 0 | -     | -
//
// one byte per cycle while req_tready is high; the 54-cell match chain updates in the accept cycle
// a result is registered in the cycle after the last byte and holds until taken
// req_tready stays high while the result register is empty or being drained
// reset is synchronous, active high; it clears the chain, found bits and result valid
module signature_byte_stream_matcher_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [4:0] found_mask, [7:5] zero
);

   localparam int unsigned PatBits = sbsm_pkg::PatBits;
   localparam int unsigned NumSigs = sbsm_pkg::NumSigs;

   logic                   req_acc;
   sbsm_pkg::sbsm_ctl_type ctl;
   logic [PatBits-1:0]     vec;      // current partial matches
   logic [PatBits-1:0]     vec_nx;   // partial matches after this byte
   logic [PatBits-1:0]     prev_vec; // each cell's left neighbor
   logic [NumSigs-1:0]     end_hit;

   logic [NumSigs-1:0] found_ff, found_in;
   logic               ended_ff, ended_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NumSigs-1:0] rsp_mask_ff, rsp_mask_in;

   // output register frees up in the same cycle it is drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;

   // a zero byte terminates the searchable text; later bytes only count for last
   assign ctl.adv = req_acc && !ended_ff && (req_tdata != 8'd0);
   assign ctl.clr = req_acc && req_tlast;

   assign prev_vec = {vec[PatBits-2:0], 1'b0};

   for (genvar k = 0; k < PatBits; k++) begin : g_cell
      sbsm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .data_byte (req_tdata),
         .pat_byte  (sbsm_pkg::pat_char(k)),
         .start     (sbsm_pkg::StartMask[k]),
         .prev_bit  (prev_vec[k]),
         .match_bit (vec[k]),
         .match_nx  (vec_nx[k])
      );
   end

   // a signature is seen when its closing cell fires
   for (genvar i = 0; i < NumSigs; i++) begin : g_end
      assign end_hit[i] = vec_nx[sbsm_pkg::SigEnd[i]];
   end

   always_comb begin
      found_in     = found_ff;
      ended_in     = ended_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mask_in  = rsp_mask_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.adv) begin
         found_in = found_ff | end_hit;
      end
      if (req_acc && !ended_ff && (req_tdata == 8'd0)) begin
         ended_in = 1'b1;
      end
      if (ctl.clr) begin
         // report the packet, then start the next one clean
         rsp_valid_in = 1'b1;
         rsp_mask_in  = found_in;
         found_in     = '0;
         ended_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= '0;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         found_ff     <= found_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mask_ff <= rsp_mask_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8-NumSigs){1'b0}}, rsp_mask_ff};

`ifndef NO_ASSERTIONS
   // a last byte always leaves a clean state and a pending result
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast |=> (found_ff == '0) && !ended_ff && (vec == '0) && rsp_valid_ff)
      else $error("state not cleared or result missing after last byte");

   // once the text has ended the match chain is frozen until the packet closes
   a_frozen_after_zero: assert property (@(posedge clock) disable iff (reset)
      ended_ff && !(req_acc && req_tlast) |=> $stable(vec))
      else $error("match chain moved after terminating zero");

   // within a packet found bits only accumulate
   a_found_grows: assert property (@(posedge clock) disable iff (reset)
      !(req_acc && req_tlast) |=> (found_ff & $past(found_ff)) == $past(found_ff))
      else $error("found bit lost within a packet");

   // no byte may be taken while an untaken result would be overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input ready while result register is blocked");
`endif

endmodule

[tb/signature_byte_stream_matcher_core_test.sv]
`timescale 1ns / 1ps

module signature_byte_stream_matcher_core_test;

   localparam int PLAN_ROWS    = 26;
   localparam int RANDOM_BYTES = 1200;
   localparam int STALL_LIMIT  = 1000;  // cycles with no transaction on either side

   // the five signatures laid end to end, first character in the top byte
   localparam logic [54*8-1:0] SIG_TEXT =
      {"eval(base64", "_decode<?php system/bin/shcmd.exepowershell"};
   // cells that open a signature
   localparam logic [53:0] FIRST_CELLS =
      (54'd1 << 0) | (54'd1 << 18) | (54'd1 << 30) | (54'd1 << 37) | (54'd1 << 44);

   // one row of the directed table
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       fixed;  // expected mask given in the row, not predicted
      logic [4:0] mask;
   } plan_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;  // [7:0] data_byte
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [4:0] found_mask, [7:5] zero

   // matcher state kept on the testbench side
   logic [53:0] chain      = '0;
   logic [4:0]  seen       = '0;
   logic        text_done  = 1'b0;

   logic [4:0]  found_q[$];   // masks waiting to come out, oldest first
   logic [7:0]  pkt_q[$];     // bytes of the packet being built
   int          bytes_sent   = 0;
   int          fail_count   = 0;
   int          idle_cycles  = 0;
   int          sink_hold    = 0;
   bit          steady_src   = 1'b0;
   bit          steady_sink  = 1'b0;

   signature_byte_stream_matcher_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] text_char(input int k);
      return SIG_TEXT[(53-k)*8 +: 8];
   endfunction

   // cells whose character equals the byte
   function automatic logic [53:0] cells_for(input logic [7:0] b);
      logic [53:0] m;
      m = '0;
      for (int k = 0; k < 54; k++)
         if (text_char(k) == b) m[k] = 1'b1;
      return m;
   endfunction

   function automatic int last_cell(input int s);
      case (s)
         0: return 17;
         1: return 29;
         2: return 36;
         3: return 43;
         default: return 53;
      endcase
   endfunction

   function automatic string sig_word(input int s);
      string head;
      head = "eval(base64";
      case (s)
         0: return {head, "_decode"};
         1: return "<?php system";
         2: return "/bin/sh";
         3: return "cmd.exe";
         default: return "powershell";
      endcase
   endfunction

   // advance the shift-and chain by one byte; a last byte yields the packet's mask
   function automatic void scan_byte(input logic [7:0] b, input logic l,
                                     output bit emit, output logic [4:0] mask);
      logic [53:0] nxt;
      emit = 1'b0;
      mask = '0;
      if (!text_done) begin
         if (b == 8'h00) begin
            // terminator: nothing after it in this packet is searched
            text_done = 1'b1;
         end else begin
            nxt   = ((chain << 1) | FIRST_CELLS) & cells_for(b);
            chain = nxt;
            for (int s = 0; s < 5; s++)
               if (nxt[last_cell(s)]) seen[s] = 1'b1;
         end
      end
      if (l) begin
         emit      = 1'b1;
         mask      = seen;
         chain     = '0;
         seen      = '0;
         text_done = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------- directed table

   function automatic plan_row_type plan_row(input int i);
      case (i)
         // single-byte packets at the extremes of the byte
         0:  return '{8'hFF, 1'b1, 1'b1, 5'b00000};
         1:  return '{8'h00, 1'b1, 1'b1, 5'b00000};  // terminator flagged last
         2:  return '{8'h01, 1'b1, 1'b1, 5'b00000};
         // one of the shortest signatures, ending on the last byte
         3:  return '{"/", 1'b0, 1'b0, 5'b00000};
         4:  return '{"b", 1'b0, 1'b0, 5'b00000};
         5:  return '{"i", 1'b0, 1'b0, 5'b00000};
         6:  return '{"n", 1'b0, 1'b0, 5'b00000};
         7:  return '{"/", 1'b0, 1'b0, 5'b00000};
         8:  return '{"s", 1'b0, 1'b0, 5'b00000};
         9:  return '{"h", 1'b1, 1'b1, 5'b00100};
         // match kept across a terminator, bytes after it ignored
         10: return '{"c", 1'b0, 1'b0, 5'b00000};
         11: return '{"m", 1'b0, 1'b0, 5'b00000};
         12: return '{"d", 1'b0, 1'b0, 5'b00000};
         13: return '{".", 1'b0, 1'b0, 5'b00000};
         14: return '{"e", 1'b0, 1'b0, 5'b00000};
         15: return '{"x", 1'b0, 1'b0, 5'b00000};
         16: return '{"e", 1'b0, 1'b0, 5'b00000};
         17: return '{8'h00, 1'b0, 1'b0, 5'b00000};
         18: return '{"x", 1'b1, 1'b1, 5'b01000};
         // signature split over two packets must not match
         19: return '{"c", 1'b0, 1'b0, 5'b00000};
         20: return '{"m", 1'b0, 1'b0, 5'b00000};
         21: return '{"d", 1'b0, 1'b0, 5'b00000};
         22: return '{".", 1'b0, 1'b0, 5'b00000};
         23: return '{"e", 1'b1, 1'b0, 5'b00000};
         24: return '{"x", 1'b0, 1'b0, 5'b00000};
         default: return '{"e", 1'b1, 1'b0, 5'b00000};
      endcase
   endfunction

   // ---------------------------------------------------------------- request side

   // present a byte, after a random gap unless steady, wait till taken, log the expectation
   task automatic push_byte(input logic [7:0] b, input logic l,
                            input logic fixed, input logic [4:0] fmask);
      int         gap;
      bit         emit;
      logic [4:0] m;
      gap = steady_src ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      scan_byte(b, l, emit, m);
      if (emit) found_q.push_back(fixed ? fmask : m);
      bytes_sent++;
   endtask

   // hold the request side until every pending mask has been taken
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (found_q.size() != 0);
   endtask

   // one random packet: mostly signature fragments, some filler and noise
   task automatic build_packet();
      int    parts;
      int    kind;
      int    n;
      int    pos;
      string w;
      pkt_q.delete();
      if ($urandom_range(0, 9) < 3) begin
         // short packet of arbitrary bytes
         n = $urandom_range(1, 3);
         repeat (n) pkt_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         parts = $urandom_range(1, 4);
         repeat (parts) begin
            kind = $urandom_range(0, 99);
            w    = sig_word($urandom_range(0, 4));
            if (kind < 40) begin
               for (int i = 0; i < w.len(); i++) pkt_q.push_back(w[i]);
            end else if (kind < 55) begin
               // prefix only, leaves a partial match hanging
               n = $urandom_range(1, w.len() - 1);
               for (int i = 0; i < n; i++) pkt_q.push_back(w[i]);
            end else if (kind < 70) begin
               // one character swapped for another signature character
               pos = $urandom_range(0, w.len() - 1);
               for (int i = 0; i < w.len(); i++)
                  pkt_q.push_back(i == pos ? text_char($urandom_range(0, 53)) : w[i]);
            end else if (kind < 90) begin
               n = $urandom_range(1, 6);
               repeat (n) pkt_q.push_back(text_char($urandom_range(0, 53)));
            end else begin
               n = $urandom_range(1, 4);
               repeat (n) pkt_q.push_back(8'($urandom_range(0, 255)));
            end
         end
      end
      // occasional terminator somewhere in the packet
      if ($urandom_range(0, 9) == 0)
         pkt_q.insert($urandom_range(0, pkt_q.size()), 8'h00);
   endtask

   initial begin
      plan_row_type row;
      int           packets;
      packets = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         row = plan_row(i);
         push_byte(row.data, row.last, row.fixed, row.mask);
      end
      drain_results();

      while (bytes_sent < PLAN_ROWS + RANDOM_BYTES) begin
         build_packet();
         steady_src = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < pkt_q.size(); i++)
            push_byte(pkt_q[i], i == pkt_q.size() - 1, 1'b0, 5'b00000);
         packets++;
         if (packets % 25 == 0) drain_results();
      end

      req_tvalid <= 1'b0;
      while (found_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("signature_byte_stream_matcher_core: match");
      end else begin
         $display("signature_byte_stream_matcher_core: mismatch");
      end
      $finish;
   end

   // ---------------------------------------------------------------- result side

   // back-pressure: a fresh random stall after each transaction, none while the sink is steady
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_hold  <= $urandom_range(0, 15);
      end else if (rsp_tvalid && rsp_tready) begin
         steady_sink = ($urandom_range(0, 7) == 0) ? !steady_sink : steady_sink;
         sink_hold  <= steady_sink ? 0 : $urandom_range(0, 15);
         rsp_tready <= steady_sink;
      end else if (!rsp_tready) begin
         if (sink_hold == 0) rsp_tready <= 1'b1;
         else                sink_hold  <= sink_hold - 1;
      end
   end

   // compare each result transaction with the oldest pending mask
   always @(posedge clock) begin
      logic [4:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (found_q.size() == 0) begin
            $error("found_mask: no result pending, got %h", rsp_tdata[4:0]);
            fail_count++;
         end else begin
            want = found_q.pop_front();
            if (rsp_tdata[4:0] !== want) begin
               $error("found_mask: expected %h, got %h", want, rsp_tdata[4:0]);
               fail_count++;
            end
            if (rsp_tdata[7:5] !== 3'b000) begin
               $error("pad: expected %h, got %h", 3'b000, rsp_tdata[7:5]);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("signature_byte_stream_matcher_core: mismatch");
         $finish;
      end
   end

endmodule
